// File: hdl/tgad_pkg.sv
// Package for the TGA pixel decoder: result codes, header constants and the
// record type passed from the decode core to the output register.
// Depends on nothing; the core, the top level and the testbench import it.
package tgad_pkg;

	// Record kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_HEADER   = 2'd1;
	localparam logic [1:0] ERR_SIZE     = 2'd2;
	localparam logic [1:0] ERR_OVERFLOW = 2'd3;

	// Header contents
	localparam logic [7:0] TYPE_RAW   = 8'd2;
	localparam logic [7:0] TYPE_RLE   = 8'd10;
	localparam logic [7:0] DEPTH_24   = 8'd24;
	localparam logic [7:0] DEPTH_32   = 8'd32;
	localparam logic [2:0] BPP_24     = 3'd3;
	localparam logic [2:0] BPP_32     = 3'd4;
	localparam logic [7:0] RUN_BIAS   = 8'd127;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_count;
		logic [31:0] pixel_index;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  bytes_per_pixel;
		logic        last_pixel;
		logic [1:0]  error_code;
	} rec_t;

endpackage

// File: hdl/tgad_if.sv
// Handshake channels of the TGA pixel decoder: the file byte stream in and
// the decoded record stream out. No dependencies.
interface tgad_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, data_byte, start_of_file, input ready);
	modport sink (input valid, data_byte, start_of_file, output ready);
endinterface

interface tgad_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_count;
	logic [31:0] pixel_index;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [2:0]  bytes_per_pixel;
	logic        last_pixel;
	logic [1:0]  error_code;

	modport source (output valid, kind, red, green, blue, alpha, repeat_count,
		pixel_index, image_width, image_height, bytes_per_pixel, last_pixel,
		error_code, input ready);
	modport sink (input valid, kind, red, green, blue, alpha, repeat_count,
		pixel_index, image_width, image_height, bytes_per_pixel, last_pixel,
		error_code, output ready);
endinterface

// File: hdl/tgad_core.sv
// Decode core of the TGA pixel decoder: the parser state and the logic that
// turns one registered file byte into the next state and an optional record.
// Depends on tgad_pkg.
module tgad_core import tgad_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] data_byte,
	input  logic       start_of_file,
	output logic       has_rec,
	output rec_t       rec
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_PACKET = 3'd2;
	localparam logic [2:0] PH_COLOUR = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;
	localparam logic [2:0] PH_ERROR  = 3'd5;

	localparam logic [4:0] POS_TYPE   = 5'd2;
	localparam logic [4:0] POS_FIXED  = 5'd12;
	localparam logic [4:0] POS_W_LO   = 5'd12;
	localparam logic [4:0] POS_W_HI   = 5'd13;
	localparam logic [4:0] POS_H_LO   = 5'd14;
	localparam logic [4:0] POS_H_HI   = 5'd15;
	localparam logic [4:0] POS_DEPTH  = 5'd16;

	logic [2:0]  phase_q,  phase_d,  e_phase;
	logic [4:0]  pos_q,    pos_d,    e_pos;
	logic        rle_q,    rle_d,    e_rle;
	logic [15:0] width_q,  width_d,  e_width;
	logic [15:0] height_q, height_d, e_height;
	logic [2:0]  dep_q,    dep_d,    e_dep;
	logic [31:0] total_q,  total_d,  e_total;
	logic [31:0] done_q,   done_d,   e_done;
	logic        run_q,    run_d,    e_run;
	logic [7:0]  rem_q,    rem_d,    e_rem;
	logic [1:0]  cpos_q,   cpos_d,   e_cpos;
	logic [31:0] cbytes_q, cbytes_d, e_cbytes;

	logic [31:0] product;
	logic [7:0]  count;
	logic [32:0] packet_end;
	logic [31:0] cbytes_new;
	logic [7:0]  covers;
	logic [31:0] done_new;
	logic        last;

	// A start of file clears every state entry before the byte is used.
	always_comb begin
		e_phase  = start_of_file ? PH_HEADER : phase_q;
		e_pos    = start_of_file ? 5'd0  : pos_q;
		e_rle    = start_of_file ? 1'b0  : rle_q;
		e_width  = start_of_file ? 16'd0 : width_q;
		e_height = start_of_file ? 16'd0 : height_q;
		e_dep    = start_of_file ? 3'd0  : dep_q;
		e_total  = start_of_file ? 32'd0 : total_q;
		e_done   = start_of_file ? 32'd0 : done_q;
		e_run    = start_of_file ? 1'b0  : run_q;
		e_rem    = start_of_file ? 8'd0  : rem_q;
		e_cpos   = start_of_file ? 2'd0  : cpos_q;
		e_cbytes = start_of_file ? 32'd0 : cbytes_q;
	end

	assign product    = {16'd0, e_width} * {16'd0, e_height};
	assign count      = data_byte[7] ? (data_byte - RUN_BIAS) : (data_byte + 8'd1);
	assign packet_end = {1'b0, e_done} + {25'd0, count};

	always_comb begin
		cbytes_new = e_cbytes;
		case (e_cpos)
			2'd0: cbytes_new[7:0]   = e_cbytes[7:0]   | data_byte;
			2'd1: cbytes_new[15:8]  = e_cbytes[15:8]  | data_byte;
			2'd2: cbytes_new[23:16] = e_cbytes[23:16] | data_byte;
			default: cbytes_new[31:24] = e_cbytes[31:24] | data_byte;
		endcase
	end

	assign covers   = e_run ? e_rem : 8'd1;
	assign done_new = e_done + {24'd0, covers};
	assign last     = (done_new >= e_total);

	always_comb begin
		phase_d  = e_phase;
		pos_d    = e_pos;
		rle_d    = e_rle;
		width_d  = e_width;
		height_d = e_height;
		dep_d    = e_dep;
		total_d  = e_total;
		done_d   = e_done;
		run_d    = e_run;
		rem_d    = e_rem;
		cpos_d   = e_cpos;
		cbytes_d = e_cbytes;

		has_rec              = 1'b0;
		rec                  = '0;
		rec.image_width      = e_width;
		rec.image_height     = e_height;

		unique case (e_phase)
			PH_HEADER: begin
				pos_d = e_pos + 5'd1;
				if (e_pos < POS_FIXED) begin
					if (e_pos == POS_TYPE) begin
						if (data_byte == TYPE_RAW) begin
							rle_d = 1'b0;
						end else if (data_byte == TYPE_RLE) begin
							rle_d = 1'b1;
						end else begin
							has_rec        = 1'b1;
							rec.kind       = KIND_ERROR;
							rec.error_code = ERR_HEADER;
							phase_d        = PH_ERROR;
						end
					end else if (data_byte != 8'd0) begin
						has_rec        = 1'b1;
						rec.kind       = KIND_ERROR;
						rec.error_code = ERR_HEADER;
						phase_d        = PH_ERROR;
					end
				end else begin
					unique case (e_pos)
						POS_W_LO: width_d  = {8'd0, data_byte};
						POS_W_HI: width_d  = {data_byte, e_width[7:0]};
						POS_H_LO: height_d = {8'd0, data_byte};
						POS_H_HI: height_d = {data_byte, e_height[7:0]};
						POS_DEPTH: begin
							if (data_byte == DEPTH_24) begin
								dep_d = BPP_24;
							end else if (data_byte == DEPTH_32) begin
								dep_d = BPP_32;
							end else begin
								dep_d = 3'd0;
							end
						end
						default: begin
							// Descriptor byte: the header is complete.
							has_rec = 1'b1;
							if (e_width == 16'd0 || e_height == 16'd0 || e_dep == 3'd0) begin
								rec.kind       = KIND_ERROR;
								rec.error_code = ERR_SIZE;
								phase_d        = PH_ERROR;
							end else begin
								rec.kind            = KIND_HEADER;
								rec.bytes_per_pixel = e_dep;
								total_d  = product;
								done_d   = 32'd0;
								cpos_d   = 2'd0;
								cbytes_d = 32'd0;
								if (e_rle) begin
									phase_d = PH_PACKET;
								end else begin
									phase_d = PH_COLOUR;
									run_d   = 1'b0;
									rem_d   = 8'd1;
								end
							end
						end
					endcase
				end
			end
			PH_PACKET: begin
				if (packet_end > {1'b0, e_total}) begin
					has_rec             = 1'b1;
					rec.kind            = KIND_ERROR;
					rec.error_code      = ERR_OVERFLOW;
					rec.bytes_per_pixel = e_dep;
					rec.pixel_index     = e_done;
					phase_d             = PH_ERROR;
				end else begin
					run_d    = data_byte[7];
					rem_d    = count;
					cpos_d   = 2'd0;
					cbytes_d = 32'd0;
					phase_d  = PH_COLOUR;
				end
			end
			PH_COLOUR: begin
				if ({1'b0, e_cpos} + 3'd1 < e_dep) begin
					cbytes_d = cbytes_new;
					cpos_d   = e_cpos + 2'd1;
				end else begin
					has_rec             = 1'b1;
					rec.kind            = KIND_PIXEL;
					rec.bytes_per_pixel = e_dep;
					rec.red             = cbytes_new[23:16];
					rec.green           = cbytes_new[15:8];
					rec.blue            = cbytes_new[7:0];
					rec.alpha           = (e_dep == BPP_32) ? cbytes_new[31:24] : 8'd0;
					rec.repeat_count    = covers;
					rec.pixel_index     = e_done;
					rec.last_pixel      = last;
					done_d   = done_new;
					cpos_d   = 2'd0;
					cbytes_d = 32'd0;
					if (last) begin
						phase_d = PH_DONE;
					end else if (!e_rle) begin
						phase_d = PH_COLOUR;
					end else if (e_run) begin
						phase_d = PH_PACKET;
					end else begin
						rem_d = e_rem - 8'd1;
						if (e_rem == 8'd1) begin
							phase_d = PH_PACKET;
						end
					end
				end
			end
			default: begin
				// Idle, done or error: bytes are ignored until the next start.
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			pos_q    <= '0;
			rle_q    <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			dep_q    <= '0;
			total_q  <= '0;
			done_q   <= '0;
			run_q    <= 1'b0;
			rem_q    <= '0;
			cpos_q   <= '0;
			cbytes_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			rle_q    <= rle_d;
			width_q  <= width_d;
			height_q <= height_d;
			dep_q    <= dep_d;
			total_q  <= total_d;
			done_q   <= done_d;
			run_q    <= run_d;
			rem_q    <= rem_d;
			cpos_q   <= cpos_d;
			cbytes_q <= cbytes_d;
		end
	end

endmodule

// File: hdl/tga_rle_pixel_decoder.sv
// Top level of the TGA pixel decoder: input register, decode core and
// output register. Depends on tgad_pkg, tgad_if and tgad_core.
//
// The decoder takes a TGA image file one byte per item on the stream
// channel; an item with start_of_file set restarts it and is read as header
// byte 0. The twelve fixed header bytes must hold type 2 (uncompressed) or
// 10 (run-length encoded) in byte 2 and zero elsewhere, followed by width,
// height, a depth of 24 or 32 bits and an ignored descriptor. Once the
// header is accepted a header record is issued, then one pixel record per
// raw pixel and a single record per run, with colours given as red, green,
// blue and alpha (alpha zero for 24-bit images). Header mismatches, bad
// sizes and packets that run past width times height give an error record,
// after which bytes are ignored until the next start; bytes after the last
// pixel are likewise ignored. Each item passes through two registers: it is
// captured in an input register, decoded by combinational logic against the
// parser state, and any record it produces lands in the output register,
// where it is presented until the consumer takes it. The block takes a new
// item in every cycle; it stalls only when the output register holds a
// record that the consumer has not yet taken. While a record waits there,
// the byte in the input register is held undecoded, and a new item can
// only enter while the input register is empty or its byte is being
// decoded.
module tga_rle_pixel_decoder import tgad_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tgad_in_if.sink     stream,
	tgad_out_if.source  records
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       sof_s1;
	logic       out_free;
	logic       advance;
	logic       has_rec;
	rec_t       rec;
	logic       out_valid_q;
	rec_t       out_q;

	// The output register can take a new result when it is empty or its
	// record is being taken in this cycle.
	assign out_free     = !out_valid_q || records.ready;
	assign advance      = valid_s1 && out_free;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			data_s1 <= stream.data_byte;
			sof_s1  <= stream.start_of_file;
		end
	end

	tgad_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.data_byte     (data_s1),
		.start_of_file (sof_s1),
		.has_rec       (has_rec),
		.rec           (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_rec) begin
			out_q <= rec;
		end
	end

	assign records.valid           = out_valid_q;
	assign records.kind            = out_q.kind;
	assign records.red             = out_q.red;
	assign records.green           = out_q.green;
	assign records.blue            = out_q.blue;
	assign records.alpha           = out_q.alpha;
	assign records.repeat_count    = out_q.repeat_count;
	assign records.pixel_index     = out_q.pixel_index;
	assign records.image_width     = out_q.image_width;
	assign records.image_height    = out_q.image_height;
	assign records.bytes_per_pixel = out_q.bytes_per_pixel;
	assign records.last_pixel      = out_q.last_pixel;
	assign records.error_code      = out_q.error_code;

endmodule

// File: test/tga_rle_pixel_decoder_test.sv
// Self-checking testbench for the TGA pixel decoder: streams whole and broken image files
// through the byte channel and checks every record against a cycle-free decoder model.
// Depends on tgad_pkg, tgad_if and the tga_rle_pixel_decoder top level.
module tga_rle_pixel_decoder_test;
	import tgad_pkg::*;

	// The model only works out what records appear; it has no notion of cycles. Stimulus is
	// built as one queue of file bytes before reset is released. The byte driver feeds that
	// queue into the block in bursts. The record monitor compares each record taken from
	// the block with the oldest prediction.

	localparam int IDLE_LIMIT  = 2000;	// cycles with no item moving on either channel
	localparam int TAIL_CYCLES = 8;	// two register stages, with margin
	localparam int BYTE_TARGET = 1600;

	typedef enum logic [2:0] {
		ST_IDLE, ST_HEADER, ST_PACKET, ST_COLOUR, ST_DONE, ST_ERROR
	} parse_state_e;

	typedef enum logic [1:0] {TAKE_ALL, TAKE_COIN, TAKE_QUARTER, TAKE_MOST} take_mode_e;

	typedef struct {
		logic [7:0] data;
		logic       sof;
		bit         drain;	// hold this byte back until every predicted record is out
	} file_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Locally held copies of the block's inputs, so that they are known from time zero.
	logic       in_valid = 1'b0;
	logic [7:0] in_data = 8'h00;
	logic       in_sof = 1'b0;
	logic       out_ready = 1'b0;

	tgad_in_if  file_bytes ();
	tgad_out_if records ();

	assign file_bytes.valid         = in_valid;
	assign file_bytes.data_byte     = in_data;
	assign file_bytes.start_of_file = in_sof;
	assign records.ready            = out_ready;

	tga_rle_pixel_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (file_bytes),
		.records (records)
	);

	initial forever #1 clk = ~clk;

	file_byte_t pending_bytes[$];
	rec_t       expected_records[$];
	int         records_predicted = 0;
	int         records_seen = 0;	// written only with nonblocking assignments
	int         mismatches = 0;
	int         idle_cycles = 0;

	// ---------------------------------------------------------------- decoder model

	parse_state_e parse_state;
	int unsigned  hdr_pos;
	bit           rle_file;
	logic [15:0]  img_w;
	logic [15:0]  img_h;
	logic [2:0]   img_bpp;
	logic [31:0]  pixel_total;
	logic [31:0]  pixels_out;
	bit           run_packet;
	logic [7:0]   packet_left;
	logic [1:0]   colour_pos;
	logic [31:0]  colour_word;

	task automatic clear_decoder();
		parse_state = ST_IDLE;
		hdr_pos     = 0;
		rle_file    = 1'b0;
		img_w       = '0;
		img_h       = '0;
		img_bpp     = '0;
		pixel_total = '0;
		pixels_out  = '0;
		run_packet  = 1'b0;
		packet_left = '0;
		colour_pos  = '0;
		colour_word = '0;
	endtask

	// An error record carries the sizes read so far. The depth is shown only once the
	// header has been accepted. After an error, bytes are ignored until the next start.
	task automatic flag_error(input logic [1:0] code, input bit accepted,
			input logic [31:0] idx, output rec_t rec);
		rec                 = '0;
		rec.kind            = KIND_ERROR;
		rec.image_width     = img_w;
		rec.image_height    = img_h;
		rec.bytes_per_pixel = accepted ? img_bpp : 3'd0;
		rec.pixel_index     = idx;
		rec.error_code      = code;
		parse_state         = ST_ERROR;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic sof,
			output bit produced, output rec_t rec);
		int unsigned pos;
		logic [8:0]  count;
		logic [32:0] reach;
		logic [7:0]  covers;
		produced = 1'b0;
		rec = '0;
		if (sof) begin
			clear_decoder();
			parse_state = ST_HEADER;
		end
		case (parse_state)
			ST_HEADER: begin
				pos = hdr_pos;
				hdr_pos = hdr_pos + 1;
				if (pos < 12) begin
					// Byte 2 selects the file type and every other fixed byte must be zero.
					if (pos == 2) begin
						if (b == TYPE_RAW) begin
							rle_file = 1'b0;
						end else if (b == TYPE_RLE) begin
							rle_file = 1'b1;
						end else begin
							flag_error(ERR_HEADER, 1'b0, '0, rec);
							produced = 1'b1;
						end
					end else if (b != 8'h00) begin
						flag_error(ERR_HEADER, 1'b0, '0, rec);
						produced = 1'b1;
					end
				end else if (pos == 12) begin
					img_w = {8'h00, b};
				end else if (pos == 13) begin
					img_w[15:8] = b;
				end else if (pos == 14) begin
					img_h = {8'h00, b};
				end else if (pos == 15) begin
					img_h[15:8] = b;
				end else if (pos == 16) begin
					img_bpp = (b == DEPTH_24) ? BPP_24 : (b == DEPTH_32) ? BPP_32 : 3'd0;
				end else begin
					// The descriptor byte itself is ignored; the sizes are judged here.
					produced = 1'b1;
					if (img_w == '0 || img_h == '0 || img_bpp == '0) begin
						flag_error(ERR_SIZE, 1'b0, '0, rec);
					end else begin
						pixel_total = img_w * img_h;
						pixels_out  = '0;
						colour_pos  = '0;
						colour_word = '0;
						if (rle_file) begin
							parse_state = ST_PACKET;
						end else begin
							parse_state = ST_COLOUR;
							run_packet  = 1'b0;
							packet_left = 8'd1;
						end
						rec.kind            = KIND_HEADER;
						rec.image_width     = img_w;
						rec.image_height    = img_h;
						rec.bytes_per_pixel = img_bpp;
					end
				end
			end
			ST_PACKET: begin
				count = b[7] ? {1'b0, b} - {1'b0, RUN_BIAS} : {1'b0, b} + 9'd1;
				reach = pixels_out + count;
				if (reach > {1'b0, pixel_total}) begin
					// No pixel of a packet that would run past the image is given out.
					flag_error(ERR_OVERFLOW, 1'b1, pixels_out, rec);
					produced = 1'b1;
				end else begin
					run_packet  = b[7];
					packet_left = count[7:0];
					colour_pos  = '0;
					colour_word = '0;
					parse_state = ST_COLOUR;
				end
			end
			ST_COLOUR: begin
				colour_word = colour_word | ({24'd0, b} << (8 * colour_pos));
				if ({1'b0, colour_pos} + 3'd1 < img_bpp) begin
					colour_pos = colour_pos + 2'd1;
				end else begin
					// Colours are stored blue first; red and blue trade places on the way out.
					covers               = run_packet ? packet_left : 8'd1;
					produced             = 1'b1;
					rec.kind             = KIND_PIXEL;
					rec.red              = colour_word[23:16];
					rec.green            = colour_word[15:8];
					rec.blue             = colour_word[7:0];
					rec.alpha            = (img_bpp == BPP_32) ? colour_word[31:24] : 8'h00;
					rec.repeat_count     = covers;
					rec.pixel_index      = pixels_out;
					rec.image_width      = img_w;
					rec.image_height     = img_h;
					rec.bytes_per_pixel  = img_bpp;
					pixels_out           = pixels_out + covers;
					rec.last_pixel       = (pixels_out >= pixel_total);
					colour_pos           = '0;
					colour_word          = '0;
					if (rec.last_pixel) begin
						parse_state = ST_DONE;
					end else if (!rle_file) begin
						parse_state = ST_COLOUR;
					end else if (run_packet) begin
						parse_state = ST_PACKET;
					end else begin
						packet_left = packet_left - 8'd1;
						if (packet_left == '0)
							parse_state = ST_PACKET;
					end
				end
			end
			default: ;
		endcase
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic put_byte(input logic [7:0] b, input logic sof, input bit drain);
		file_byte_t fb;
		fb.data  = b;
		fb.sof   = sof;
		fb.drain = drain;
		pending_bytes.push_back(fb);
	endtask

	task automatic put_pixel(input int unsigned bpp);
		repeat (bpp) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endtask

	task automatic put_junk();
		repeat ($urandom_range(0, 3)) put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endtask

	task automatic put_header(input logic [7:0] img_type, input logic [15:0] w,
			input logic [15:0] h, input logic [7:0] depth, input bit drain);
		put_byte(8'h00, 1'b1, drain);
		put_byte(8'h00, 1'b0, 1'b0);
		put_byte(img_type, 1'b0, 1'b0);
		repeat (9) put_byte(8'h00, 1'b0, 1'b0);
		put_byte(w[7:0], 1'b0, 1'b0);
		put_byte(w[15:8], 1'b0, 1'b0);
		put_byte(h[7:0], 1'b0, 1'b0);
		put_byte(h[15:8], 1'b0, 1'b0);
		put_byte(depth, 1'b0, 1'b0);
		put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
	endtask

	// One file of a randomly chosen shape. Most are well formed, so that pixel decoding is
	// reached often. The rest break the header or the sizes, overrun the image, are cut
	// short by the next start, or are plain noise.
	task automatic queue_random_file();
		int unsigned variant, pos, i, w, h, bpp, total, rem, cnt, cap, budget, start_size;
		bit          rle, drain, overflow, run, huge;
		logic [7:0]  b, depth;
		variant = $urandom_range(0, 99);
		drain   = ($urandom_range(0, 15) == 0);
		rle     = 1'($urandom_range(0, 1));
		depth   = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
		if (variant < 8) begin
			// Header mismatch at a random fixed byte.
			pos = $urandom_range(0, 11);
			for (i = 0; i <= pos; i++) begin
				if (i == 2 && i == pos) begin
					do b = 8'($urandom_range(0, 255)); while (b == TYPE_RAW || b == TYPE_RLE);
				end else if (i == 2) begin
					b = rle ? TYPE_RLE : TYPE_RAW;
				end else if (i == pos) begin
					b = 8'($urandom_range(1, 255));
				end else begin
					b = 8'h00;
				end
				put_byte(b, i == 0, drain && i == 0);
			end
			put_junk();
		end else if (variant < 16) begin
			// Zero width, zero height or an unsupported depth.
			w = $urandom_range(0, 65535);
			h = $urandom_range(0, 65535);
			case ($urandom_range(0, 2))
				0: w = 0;
				1: h = 0;
				default: begin
					do depth = 8'($urandom_range(0, 255));
					while (depth == DEPTH_24 || depth == DEPTH_32);
				end
			endcase
			put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), depth, drain);
			put_junk();
		end else if (variant < 20) begin
			repeat ($urandom_range(1, 8))
				put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
		end else begin
			bpp  = (depth == DEPTH_32) ? 4 : 3;
			huge = (variant < 26);
			if (huge) begin
				// Far too large to finish; the next start cuts it short.
				w      = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
				h      = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
				budget = $urandom_range(0, 24);
			end else begin
				if (rle && $urandom_range(0, 5) == 0) begin
					w = $urandom_range(128, 300);
					h = 1;
				end else begin
					w = $urandom_range(1, 5);
					h = $urandom_range(1, 4);
				end
				budget = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 30) : 32'hFFFF_FFFF;
			end
			overflow = rle && ($urandom_range(0, 7) == 0);
			put_header(rle ? TYPE_RLE : TYPE_RAW, 16'(w), 16'(h), depth, drain);
			total      = w * h;
			rem        = total;
			start_size = pending_bytes.size();
			while (rem != 0 && pending_bytes.size() - start_size < budget) begin
				run = 1'($urandom_range(0, 1));
				if (!rle) begin
					put_pixel(bpp);
					rem--;
				end else if (overflow && rem < 128 && $urandom_range(0, 2) == 0) begin
					// A packet that asks for more pixels than remain.
					cnt = $urandom_range(rem + 1, 128);
					put_byte(8'(run ? cnt + RUN_BIAS : cnt - 1), 1'b0, 1'b0);
					put_junk();
					return;
				end else begin
					cap = (rem < 128) ? rem : 128;
					if (run)
						cnt = ($urandom_range(0, 4) == 0) ? cap : $urandom_range(1, cap);
					else if (!huge && $urandom_range(0, 4) == 0)
						cnt = cap;
					else
						cnt = $urandom_range(1, (cap < 4) ? cap : 4);
					put_byte(8'(run ? cnt + RUN_BIAS : cnt - 1), 1'b0, 1'b0);
					if (run)
						put_pixel(bpp);
					else
						repeat (cnt) put_pixel(bpp);
					rem -= cnt;
				end
			end
			// Bytes after the last pixel are ignored until the next start.
			if (rem == 0 && $urandom_range(0, 2) == 0)
				put_junk();
		end
	endtask

	// ---------------------------------------------------------------- byte driver

	bit         burst_new;
	int         burst_left;
	int         gap_left;

	always @(posedge clk or negedge arst_n) begin : byte_driver
		bit         produced;
		bit         send;
		rec_t       predicted;
		file_byte_t next_byte;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= 8'h00;
			in_sof     <= 1'b0;
			burst_left = 1;
			gap_left   = 0;
			clear_decoder();
		end else begin
			if (file_bytes.valid && file_bytes.ready) begin
				decode_byte(file_bytes.data_byte, file_bytes.start_of_file, produced, predicted);
				if (produced) begin
					expected_records.push_back(predicted);
					records_predicted++;
				end
			end
			if (!file_bytes.valid || file_bytes.ready) begin
				send = 1'b0;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_bytes.size() != 0 &&
						!(pending_bytes[0].drain && records_predicted != records_seen)) begin
					next_byte = pending_bytes.pop_front();
					send      = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						if ($urandom_range(0, 3) == 0)
							gap_left = 0;
						else if ($urandom_range(0, 7) == 0)
							gap_left = $urandom_range(4, 12);
						else
							gap_left = $urandom_range(1, 3);
					end
				end
				in_valid <= send;
				if (send) begin
					in_data <= next_byte.data;
					in_sof  <= next_byte.sof;
				end
			end
		end
	end

	// ---------------------------------------------------------------- record receiver

	take_mode_e take_mode;
	logic [5:0] take_cycle;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			take_mode  = TAKE_ALL;
			take_cycle = '0;
		end else begin
			take_cycle = take_cycle + 6'd1;
			if (take_cycle == '0)
				take_mode = take_mode_e'($urandom_range(0, 3));
			case (take_mode)
				TAKE_ALL:     out_ready <= 1'b1;
				TAKE_COIN:    out_ready <= 1'($urandom_range(0, 1));
				TAKE_QUARTER: out_ready <= (take_cycle[1:0] == 2'd0);
				default:      out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic string describe(rec_t r);
		return $sformatf({"kind=%0d rgba=%02h %02h %02h %02h rep=%0d idx=%0d w=%0d h=%0d",
			" bpp=%0d last=%0d err=%0d"}, r.kind, r.red, r.green, r.blue, r.alpha,
			r.repeat_count, r.pixel_index, r.image_width, r.image_height,
			r.bytes_per_pixel, r.last_pixel, r.error_code);
	endfunction

	always @(posedge clk) begin : record_monitor
		rec_t got;
		rec_t want;
		if (arst_n && records.valid && records.ready) begin
			got = {records.kind, records.red, records.green, records.blue, records.alpha,
				records.repeat_count, records.pixel_index, records.image_width,
				records.image_height, records.bytes_per_pixel, records.last_pixel,
				records.error_code};
			if (expected_records.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected record: %s", describe(got));
			end else begin
				want = expected_records.pop_front();
				records_seen <= records_seen + 1;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("record mismatch, expected: %s", describe(want));
						$display("                   actual: %s", describe(got));
					end
				end
			end
		end
	end

	// Watchdog: counts cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if (!arst_n || (file_bytes.valid && file_bytes.ready) || (records.valid && records.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// ---------------------------------------------------------------- run control

	initial begin
		// Directed opening: bytes before any start, a mismatch at the very first header
		// byte, then the smallest possible RLE image in 32-bit colour, followed by a
		// stray byte after its last pixel. This file waits for the error record to
		// arrive before it starts.
		put_byte(8'hFF, 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b0);
		put_byte(8'h05, 1'b1, 1'b0);
		put_byte(8'hAA, 1'b0, 1'b0);
		put_header(TYPE_RLE, 16'd1, 16'd1, DEPTH_32, 1'b1);
		put_byte(8'h80, 1'b0, 1'b0);
		put_byte(8'h11, 1'b0, 1'b0);
		put_byte(8'h22, 1'b0, 1'b0);
		put_byte(8'h33, 1'b0, 1'b0);
		put_byte(8'h44, 1'b0, 1'b0);
		put_byte(8'h00, 1'b0, 1'b0);
		while (pending_bytes.size() < BYTE_TARGET)
			queue_random_file();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (!(pending_bytes.size() == 0 && !in_valid && records_predicted == records_seen)
				&& idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (idle_cycles >= IDLE_LIMIT || mismatches != 0 || expected_records.size() != 0)
			$display("== FAIL ==");
		else
			$display("== PASS ==");
		$finish;
	end

endmodule

// File: filelist.f
hdl/tgad_pkg.sv
hdl/tgad_if.sv
hdl/tgad_core.sv
hdl/tga_rle_pixel_decoder.sv
test/tga_rle_pixel_decoder_test.sv
